// File: rtl/ws2812_pulse_width_encoder_assert.svh
// ---------------------------------------------------------------------------
// ws2812 pulse width encoder assertion macros
// shared concurrent check forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef WS2812_PULSE_WIDTH_ENCODER_ASSERT_SVH
`define WS2812_PULSE_WIDTH_ENCODER_ASSERT_SVH

// same-cycle implication
`define WSPWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSPWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wspwe_pkg.sv
// ---------------------------------------------------------------------------
// wspwe_pkg
// types and constants of the ws2812 pulse width encoder
// ---------------------------------------------------------------------------
package wspwe_pkg;

  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned CNT_W        = 5;
  localparam logic [CNT_W-1:0] CNT_LAST_BIT = 5'd23;
  localparam logic [CNT_W-1:0] CNT_LATCH    = 5'd24;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_PULSE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PULSE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT        = 2'd2;

  localparam logic [8:0] LED_COUNT_RESET = 9'd3;

  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        latch_slot;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [BITS_PER_LED-1:0] grb;
    logic                    latch;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// File: rtl/wspwe_front.sv
// ---------------------------------------------------------------------------
// wspwe_front
// accepts led requests, drops out-of-chain positions, packs grb and flags
// the last led of the frame
// ---------------------------------------------------------------------------
module wspwe_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  wspwe_pkg::in_item_t in_data,
  input  logic [8:0]          led_count,
  input  wspwe_pkg::q_status_t q_status,
  output logic                push,
  output wspwe_pkg::q_entry_t push_entry
);
  import wspwe_pkg::*;

  logic [8:0] pos;
  logic       in_range;

  assign pos      = {1'b0, in_data.led_index};
  assign in_range = pos < led_count;
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && in_range;

  assign push_entry.grb   = {in_data.green, in_data.red, in_data.blue};
  assign push_entry.latch = (pos + 9'd1) == led_count;

endmodule

// File: rtl/wspwe_queue.sv
// ---------------------------------------------------------------------------
// wspwe_queue
// two-entry queue between front and back
// ---------------------------------------------------------------------------
module wspwe_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wspwe_pkg::q_entry_t   push_entry,
  input  logic                  pop,
  output wspwe_pkg::q_entry_t   pop_entry,
  output wspwe_pkg::q_status_t  q_status
);
  import wspwe_pkg::*;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry      = mem_r[rd_ptr_r];
  assign q_status.valid = cnt_r != 2'd0;
  assign q_status.full  = cnt_r == 2'd2;

endmodule

// File: rtl/wspwe_back.sv
// ---------------------------------------------------------------------------
// wspwe_back
// serializes one grb word into pulse width results, msb first, plus the
// latch slot for a frame's last led, through a registered output stage
// ---------------------------------------------------------------------------
`include "ws2812_pulse_width_encoder_assert.svh"

module wspwe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wspwe_pkg::q_status_t  q_status,
  input  wspwe_pkg::q_entry_t   pop_entry,
  output logic                  pop,
  input  logic [15:0]           one_width,
  input  logic [15:0]           zero_width,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wspwe_pkg::out_item_t  out_data
);
  import wspwe_pkg::*;

  logic [BITS_PER_LED-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    latch_r, latch_nxt;
  logic                    busy_r, busy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic                    load_ok;
  logic                    adv;
  logic                    fin;
  logic                    in_latch_slot;

  assign load_ok       = !out_valid_r || !out_stall;
  assign adv           = busy_r && load_ok;
  assign in_latch_slot = cnt_r == CNT_LATCH;
  assign fin           = adv && (latch_r ? in_latch_slot : (cnt_r == CNT_LAST_BIT));
  assign pop           = q_status.valid && (!busy_r || fin);

  always_comb begin
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    latch_nxt = latch_r;
    busy_nxt  = busy_r;
    if (pop) begin
      word_nxt  = pop_entry.grb;
      latch_nxt = pop_entry.latch;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (adv) begin
      cnt_nxt  = cnt_r + CNT_W'(1);
      word_nxt = {word_r[BITS_PER_LED-2:0], 1'b0};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_ok) begin
      out_valid_nxt = adv;
    end
    if (adv) begin
      if (in_latch_slot) begin
        out_data_nxt.pulse_width = '0;
        out_data_nxt.latch_slot  = 1'b1;
        out_data_nxt.last_of_run = 1'b1;
      end else begin
        out_data_nxt.pulse_width = word_r[BITS_PER_LED-1] ? one_width : zero_width;
        out_data_nxt.latch_slot  = 1'b0;
        out_data_nxt.last_of_run = !latch_r && (cnt_r == CNT_LAST_BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    cnt_r      <= cnt_nxt;
    latch_r    <= latch_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WSPWE_ASSERT_NOW(a_latch_slot_form, out_valid_r && out_data_r.latch_slot,
    out_data_r.last_of_run && (out_data_r.pulse_width == '0), "latch slot malformed")
  `WSPWE_ASSERT_NOW(a_pop_nonempty, pop, q_status.valid, "pop from empty queue")
  `WSPWE_ASSERT_NOW(a_cnt_range, busy_r,
    (cnt_r < CNT_LATCH) || (latch_r && in_latch_slot), "bit counter out of range")
  `WSPWE_ASSERT_NEXT(a_fin_hands_over, fin && !q_status.valid, !busy_r,
    "serializer busy after last result")

endmodule

// File: rtl/ws2812_pulse_width_encoder.sv
// ---------------------------------------------------------------------------
// ws2812_pulse_width_encoder
// grb led color to per-bit pwm compare value encoder
// ---------------------------------------------------------------------------
// Each led request yields 24 pulse width results, green msb first, then red,
// then blue; the led at position led_count-1 adds a 25th zero-width latch
// slot. The serializer emits one result per cycle while out_stall is low;
// a position at or beyond led_count is taken and gives nothing. A two-entry
// queue lets the front keep taking requests while the serializer works, and
// pulse widths are kept to min(PULSE_WIDTH_BITS, 16) bits.
// ---------------------------------------------------------------------------
module ws2812_pulse_width_encoder #(
  parameter int unsigned PULSE_WIDTH_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  wspwe_pkg::in_item_t                     in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output wspwe_pkg::out_item_t                    out_data,
  input  logic                                    cfg_we,
  input  logic [wspwe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wspwe_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import wspwe_pkg::*;

  localparam int unsigned STORE_W = (PULSE_WIDTH_BITS < 16) ? PULSE_WIDTH_BITS : 16;

  logic [STORE_W-1:0] one_r, one_nxt;
  logic [STORE_W-1:0] zero_r, zero_nxt;
  logic [8:0]         led_count_r, led_count_nxt;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  pop_entry;
  logic      push;
  logic      pop;

  always_comb begin
    one_nxt       = one_r;
    zero_nxt      = zero_r;
    led_count_nxt = led_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_PULSE_WIDTH:  one_nxt       = cfg_data[STORE_W-1:0];
        CFG_ZERO_PULSE_WIDTH: zero_nxt      = cfg_data[STORE_W-1:0];
        CFG_LED_COUNT:        led_count_nxt = cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_r       <= '0;
      zero_r      <= '0;
      led_count_r <= LED_COUNT_RESET;
    end else begin
      one_r       <= one_nxt;
      zero_r      <= zero_nxt;
      led_count_r <= led_count_nxt;
    end
  end

  wspwe_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .led_count  (led_count_r),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  wspwe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  wspwe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .one_width  (16'(one_r)),
    .zero_width (16'(zero_r)),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: tb/sv/ws2812_pulse_width_encoder_checker.sv
// ---------------------------------------------------------------------------
// ws2812_pulse_width_encoder_checker
// register shadow, per-request slot prediction and in-order result compare
// ---------------------------------------------------------------------------
module ws2812_pulse_width_encoder_checker #(
  parameter int unsigned PULSE_WIDTH_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  wspwe_pkg::in_item_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  wspwe_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [wspwe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wspwe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               pending,
  output int                               fail_count
);

  import wspwe_pkg::*;

  localparam logic [63:0] WIDTH_MASK = ((64'd1 << PULSE_WIDTH_BITS) - 64'd1) & 64'hFFFF;

  logic [15:0] one_width;
  logic [15:0] zero_width;
  logic [8:0]  chain_len;
  out_item_t   slot_q[$];
  out_item_t   head;

  task automatic encode_led(input in_item_t led);
    logic [23:0] grb;
    logic        ends_frame;
    out_item_t   slot;
    int          k;
    if ({1'b0, led.led_index} >= chain_len) return;
    ends_frame = (({1'b0, led.led_index} + 9'd1) == chain_len);
    grb = {led.green, led.red, led.blue};
    for (k = 0; k < BITS_PER_LED; k++) begin
      slot.pulse_width = (grb[BITS_PER_LED-1-k] ? one_width : zero_width) & WIDTH_MASK[15:0];
      slot.latch_slot  = 1'b0;
      slot.last_of_run = !ends_frame && (k == BITS_PER_LED - 1);
      slot_q.push_back(slot);
    end
    if (ends_frame) begin
      slot.pulse_width = '0;
      slot.latch_slot  = 1'b1;
      slot.last_of_run = 1'b1;
      slot_q.push_back(slot);
    end
  endtask

  task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      one_width  = '0;
      zero_width = '0;
      chain_len  = LED_COUNT_RESET;
      slot_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (slot_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          head = slot_q.pop_front();
          if (out_data.pulse_width !== head.pulse_width)
            report("pulse_width", head.pulse_width, out_data.pulse_width);
          if (out_data.latch_slot !== head.latch_slot)
            report("latch_slot", 16'(head.latch_slot), 16'(out_data.latch_slot));
          if (out_data.last_of_run !== head.last_of_run)
            report("last_of_run", 16'(head.last_of_run), 16'(out_data.last_of_run));
        end
      end
      if (in_valid && !in_stall) encode_led(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ONE_PULSE_WIDTH:  one_width = cfg_data;
          CFG_ZERO_PULSE_WIDTH: zero_width = cfg_data;
          CFG_LED_COUNT:        chain_len = cfg_data[8:0];
          default: ;
        endcase
      end
    end
    pending = slot_q.size();
  end

endmodule

// File: tb/sv/ws2812_pulse_width_encoder_tb.sv
// ---------------------------------------------------------------------------
// ws2812_pulse_width_encoder_tb
// led requests with random gaps and result stalls, a long hold-off and a
// drain pause, over directed and random register settings
// ---------------------------------------------------------------------------
module ws2812_pulse_width_encoder_tb;

  import wspwe_pkg::*;

  localparam int unsigned PULSE_WIDTH_BITS = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          pending;
  int          fail_count;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stuck_cycles;
  bit          idle_en = 1'b1;
  bit          stall_en = 1'b1;
  logic [8:0]  chain_len = LED_COUNT_RESET;

  always #5 clk = ~clk;

  ws2812_pulse_width_encoder #(.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ws2812_pulse_width_encoder_checker #(.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)) i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  // result side: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_en && ($urandom_range(99) < 26);
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("ws2812_pulse_width_encoder_tb NOT OK");
    $finish;
  end

  function automatic in_item_t led_item(input logic [7:0] idx, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    in_item_t item;
    item.led_index = idx;
    item.red       = r;
    item.green     = g;
    item.blue      = b;
    return item;
  endfunction

  task automatic send_led(input in_item_t item);
    while (idle_en && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input logic [7:0] idx);
    send_led(led_item(idx, 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] one_w, input logic [15:0] zero_w,
                           input logic [8:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ONE_PULSE_WIDTH;
    cfg_data  <= one_w;
    @(negedge clk);
    cfg_index <= CFG_ZERO_PULSE_WIDTH;
    cfg_data  <= zero_w;
    @(negedge clk);
    cfg_index <= CFG_LED_COUNT;
    cfg_data  <= {7'($urandom), count};
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 16'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b0;
    chain_len = count;
  endtask

  initial begin
    int         phase;
    int         counted;
    int         sent;
    int         span;
    int         len;
    int         idx;
    bit         paused;
    logic [15:0] one_w;
    logic [15:0] zero_w;
    logic [8:0]  count;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values, chain of three
    send_led(led_item(8'd0, 8'h00, 8'hFF, 8'hAA));
    send_led(led_item(8'd2, 8'h12, 8'h34, 8'h56));
    send_led(led_item(8'd3, 8'hFF, 8'hFF, 8'hFF));
    send_led(led_item(8'd255, 8'h01, 8'h02, 8'h03));
    wait_drain();

    // single led chain, full and empty widths
    configure(16'hFFFF, 16'h0000, 9'd1);
    send_led(led_item(8'd0, 8'hFF, 8'hFF, 8'hFF));
    send_led(led_item(8'd0, 8'h00, 8'h00, 8'h00));
    send_led(led_item(8'd1, 8'h80, 8'h01, 8'h7E));
    send_led(led_item(8'd0, 8'h55, 8'hAA, 8'h0F));
    wait_drain();

    // longest chain the index range covers, widths swapped
    configure(16'h0000, 16'hFFFF, 9'd256);
    send_led(led_item(8'd255, 8'hA5, 8'h5A, 8'hC3));
    send_led(led_item(8'd254, 8'hF0, 8'h0F, 8'h3C));
    send_led(led_item(8'd0, 8'h01, 8'h80, 8'hFE));
    wait_drain();

    // empty chain gives nothing
    configure(16'h1234, 16'h8001, 9'd0);
    send_led(led_item(8'd0, 8'hFF, 8'h00, 8'hFF));
    send_led(led_item(8'd128, 8'h00, 8'hFF, 8'h00));
    wait_drain();

    // chain longer than the index range never latches
    configure(16'hA5A5, 16'h5A5A, 9'd300);
    send_led(led_item(8'd255, 8'hC0, 8'h03, 8'h99));
    send_led(led_item(8'd0, 8'h66, 8'h99, 8'h33));
    wait_drain();
    configure(16'h7FFF, 16'h8000, 9'd511);
    send_led(led_item(8'd255, 8'hFF, 8'hFF, 8'hFF));

    for (phase = 0; phase < 6; phase++) begin
      wait_drain();
      case ($urandom_range(3))
        0: begin one_w = 16'hFFFF; zero_w = 16'h0000; end
        1: begin one_w = 16'h0000; zero_w = 16'hFFFF; end
        default: begin one_w = 16'($urandom); zero_w = 16'($urandom); end
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: count = 9'($urandom_range(8, 1));
        6, 7:             count = 9'($urandom_range(256, 1));
        8:                count = 9'd0;
        default:          count = 9'($urandom_range(511, 257));
      endcase
      if (phase == 5) count = 9'd256;
      // hold-off and pause phases need results in flight
      if ((phase == 2 || phase == 3) && count == 9'd0) count = 9'd8;
      configure(one_w, zero_w, count);
      idle_en  = (phase != 4);
      stall_en = (phase != 4);
      if (phase == 2) hold_reqs++;
      counted = 0;
      sent    = 0;
      paused  = 1'b0;
      while (counted < 36 && sent < 70) begin
        if (phase == 3 && !paused && sent >= 20) begin
          wait_drain();
          paused = 1'b1;
        end
        if (chain_len != 0 && $urandom_range(99) < 80) begin
          // well-formed frame tail ending at the last led within the index range
          span = (chain_len > 256) ? 256 : int'(chain_len);
          len  = (span <= 8) ? span : $urandom_range(8, 1);
          for (idx = span - len; idx < span; idx++) send_random(8'(idx));
          counted += len;
          sent    += len;
        end else begin
          idx = $urandom_range(255);
          send_random(8'(idx));
          if (idx < chain_len) counted++;
          sent++;
        end
      end
    end

    idle_en  = 1'b1;
    stall_en = 1'b1;
    wait_drain();
    if (fail_count == 0 && pending == 0)
      $display("ws2812_pulse_width_encoder_tb OK");
    else
      $display("ws2812_pulse_width_encoder_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/wspwe_pkg.sv
rtl/wspwe_front.sv
rtl/wspwe_queue.sv
rtl/wspwe_back.sv
rtl/ws2812_pulse_width_encoder.sv
tb/sv/ws2812_pulse_width_encoder_checker.sv
tb/sv/ws2812_pulse_width_encoder_tb.sv
